// File: design/window_median_filter_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the window median filter
// Shared wrappers for the concurrent checks in the checker module.
// ----------------------------------------------------------------------------
`ifndef WINDOW_MEDIAN_FILTER_UNIT_MACROS_SVH
`define WINDOW_MEDIAN_FILTER_UNIT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is high.
`define WMF_ASSERT(name, clk_e, rst_e, prop) \
  name: assert property (@(posedge clk_e) disable iff (rst_e) prop) \
    else $error("window median filter check failed");

// Check a property on every rising edge, reset included.
`define WMF_ASSERT_ALWAYS(name, clk_e, prop) \
  name: assert property (@(posedge clk_e) prop) \
    else $error("window median filter check failed");

`endif

// File: design/wmf_pkg.sv
// ----------------------------------------------------------------------------
// Window median filter package
// Shared widths, defaults, register indexes and types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package wmf_pkg;

  localparam int PIX_W    = 8;
  localparam int WS_W     = 3;
  localparam int DIM_W    = 12;
  localparam int OUT_POS_W = 11;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_MAX_WINDOW = 7;
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  localparam logic [WS_W-1:0]  RST_WINDOW_SIZE  = 3'd3;
  localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 12'd640;
  localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 12'd480;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_GATHER,
    ST_LAST,
    ST_MED
  } wmf_state_t;

  // Link between neighboring sort cells.
  typedef struct packed {
    logic             keep;
    logic             valid;
    logic [PIX_W-1:0] value;
  } wmf_link_t;

endpackage
`default_nettype wire

// File: design/wmf_sort_cell.sv
// ----------------------------------------------------------------------------
// Insertion sort cell
// Holds one sorted value; on insert keeps it, takes the new value or shifts
// in its lower neighbor's value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module wmf_sort_cell
  import wmf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             clear,
  input  wire logic             ins_en,
  input  wire logic [PIX_W-1:0] ins_val,
  input  wire wmf_link_t        prev,
  output wmf_link_t             link
);

  logic             valid;
  logic [PIX_W-1:0] value;
  logic             keep;

  assign keep = valid && (value <= ins_val);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= 1'b0;
    end else if (ins_en && !keep) begin
      if (prev.keep) begin
        value <= ins_val;
        valid <= 1'b1;
      end else begin
        value <= prev.value;
        valid <= prev.valid;
      end
    end
  end

  assign link = '{keep: keep, valid: valid, value: value};

endmodule
`default_nettype wire

// File: design/window_median_filter_unit.sv
// ----------------------------------------------------------------------------
// Window median filter unit
// Two-dimensional lower-median filter over one raster-order grayscale frame.
// ----------------------------------------------------------------------------
//
//  channel  | direction | transfer carries
//  ---------+-----------+------------------------------------------------
//  s_*      | in        | tdata: pixel_in; tuser: func (1 = flush tick)
//  m_*      | out       | tdata: pixel_out, out_col, out_row; tlast: frame_done
//  cfg_*    | in        | register write: index, data (no handshake)
//
//  States: an item that yields no result passes the store and check states.
//  An item that yields a result goes on through gather, last and pick:
//  the line store has one read port, so the window is fetched one cell a
//  cycle into the sort chain, then the median is picked and registered.
//  Reset: synchronous, clears positions and the config to its defaults;
//  the line store needs no clearing pass. A finished result waits in the
//  output register while the next item is taken; if it is still unread when
//  the next result is ready, the unit holds in the pick state.
//
`timescale 1ns / 1ps
`default_nettype none
module window_median_filter_unit
  import wmf_pkg::*;
#(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW,
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [PIX_W-1:0]     s_tdata,   // [7:0] pixel_in
  input  wire logic                 s_tuser,   // [0] func
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [31:0]               m_tdata,   // [7:0] pixel_out, [18:8] out_col,
                                               // [29:19] out_row, [31:30] zero
  output logic                      m_tlast,   // frame_done
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data
);

  localparam int RING  = MAX_WINDOW + 1;
  localparam int RGW   = $clog2(RING);
  localparam int DEPTH = RING * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int SW    = $clog2(MAX_WINDOW + 1);
  localparam int NCELL = MAX_WINDOW * MAX_WINDOW;
  localparam int IW    = (NCELL > 1) ? $clog2(NCELL) : 1;

  // Configuration registers, raw as written.
  logic [WS_W-1:0]  ws_reg;
  logic [DIM_W-1:0] fw_reg;
  logic [DIM_W-1:0] fh_reg;

  // Effective (clamped) values.
  logic [SW-1:0] s_eff, k_eff, d_eff;
  logic [CW:0]   w_eff;
  logic [RW:0]   h_eff;

  always_comb begin
    if (ws_reg == '0) s_eff = SW'(1);
    else if (32'(ws_reg) > 32'(MAX_WINDOW)) s_eff = SW'(MAX_WINDOW);
    else s_eff = SW'(ws_reg);
    if (fw_reg == '0) w_eff = (CW+1)'(1);
    else if (32'(fw_reg) > 32'(MAX_WIDTH)) w_eff = (CW+1)'(MAX_WIDTH);
    else w_eff = (CW+1)'(fw_reg);
    if (fh_reg == '0) h_eff = (RW+1)'(1);
    else if (32'(fh_reg) > 32'(MAX_HEIGHT)) h_eff = (RW+1)'(MAX_HEIGHT);
    else h_eff = (RW+1)'(fh_reg);
    k_eff = (s_eff - SW'(1)) >> 1;
    d_eff = s_eff - SW'(1) - k_eff;
  end

  // Input and output positions.
  logic [CW-1:0]  in_col, emit_col;
  logic [RW-1:0]  in_row, emit_row;
  logic [RGW-1:0] in_ring, emit_ring;
  logic           in_done;

  wmf_state_t state, state_next;

  // Window walk.
  logic signed [RW+1:0] r_cur;
  logic signed [CW+1:0] c_cur, c_base;
  logic [RGW-1:0]       g_ring;
  logic [SW-1:0]        gx, gy;
  logic [IW-1:0]        med_idx;

  // Line store.
  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rd_data;
  logic             wr_en, rd_en;
  logic [AW-1:0]    wr_addr, rd_addr;

  // Sort chain control.
  logic             ins_en_d, ins_zero_d, sort_clear;
  logic [PIX_W-1:0] ins_val;
  logic [PIX_W-1:0] median;

  // Output register.
  logic                 out_full;
  logic [PIX_W-1:0]     out_pix;
  logic [OUT_POS_W-1:0] out_col, out_row;
  logic                 out_last;

  logic in_take, out_free, emit_ready, in_frame, emit_last, cfg_hit;
  logic [RW:0] rr;
  logic [CW:0] rc;
  logic [SW+SW-1:0] sq;
  logic [RGW:0] ring_start;

  assign in_take  = s_tvalid && s_tready;
  assign out_free = !out_full || m_tready;
  assign cfg_hit  = cfg_we && ((cfg_index == REG_WINDOW_SIZE) ||
                    (cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT));

  // Readiness of the next output: the farthest pixel it needs has arrived.
  always_comb begin
    rr = (RW+1)'(emit_row) + (RW+1)'(d_eff);
    if (rr > h_eff - (RW+1)'(1)) rr = h_eff - (RW+1)'(1);
    rc = (CW+1)'(emit_col) + (CW+1)'(d_eff);
    if (rc > w_eff - (CW+1)'(1)) rc = w_eff - (CW+1)'(1);
    emit_ready = in_done || (rr < (RW+1)'(in_row)) ||
                 ((rr == (RW+1)'(in_row)) && (rc < (CW+1)'(in_col)));
    emit_last  = ((RW+1)'(emit_row) == h_eff - (RW+1)'(1)) &&
                 ((CW+1)'(emit_col) == w_eff - (CW+1)'(1));
    sq         = (SW+SW)'(s_eff) * (SW+SW)'(s_eff);
    ring_start = (RGW+1)'(emit_ring) + (RGW+1)'(RING) - (RGW+1)'(k_eff);
    if (ring_start >= (RGW+1)'(RING)) ring_start = ring_start - (RGW+1)'(RING);
    in_frame   = (r_cur >= 0) && (c_cur >= 0) &&
                 (r_cur < $signed({1'b0, h_eff})) && (c_cur < $signed({1'b0, w_eff}));
  end

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    sort_clear = 1'b0;
    rd_en      = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (emit_ready) begin
          sort_clear = 1'b1;
          state_next = ST_GATHER;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_GATHER: begin
        rd_en = in_frame;
        if ((gy == s_eff - SW'(1)) && (gx == s_eff - SW'(1))) state_next = ST_LAST;
      end
      ST_LAST: state_next = ST_MED;
      ST_MED: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Line store: one write port for arriving pixels, one read port for the walk.
  assign wr_en   = in_take && !s_tuser && !in_done;
  assign wr_addr = AW'(in_ring) * AW'(MAX_WIDTH) + AW'(in_col);
  assign rd_addr = AW'(g_ring) * AW'(MAX_WIDTH) + AW'(c_cur[CW-1:0]);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= s_tdata;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // Positions, config and the window walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      ws_reg    <= RST_WINDOW_SIZE;
      fw_reg    <= RST_FRAME_WIDTH;
      fh_reg    <= RST_FRAME_HEIGHT;
      in_col    <= '0;
      in_row    <= '0;
      in_ring   <= '0;
      in_done   <= 1'b0;
      emit_col  <= '0;
      emit_row  <= '0;
      emit_ring <= '0;
    end else if (cfg_hit) begin
      // Any register write restarts the frame; stored pixels stay.
      case (cfg_index)
        REG_WINDOW_SIZE:  ws_reg <= cfg_data[WS_W-1:0];
        REG_FRAME_WIDTH:  fw_reg <= cfg_data;
        REG_FRAME_HEIGHT: fh_reg <= cfg_data;
        default: ;
      endcase
      in_col    <= '0;
      in_row    <= '0;
      in_ring   <= '0;
      in_done   <= 1'b0;
      emit_col  <= '0;
      emit_row  <= '0;
      emit_ring <= '0;
    end else begin
      if (wr_en) begin
        if ((CW+1)'(in_col) + (CW+1)'(1) >= w_eff) begin
          in_col <= '0;
          if ((RW+1)'(in_row) + (RW+1)'(1) >= h_eff) begin
            in_row  <= '0;
            in_ring <= '0;
            in_done <= 1'b1;
          end else begin
            in_row  <= in_row + RW'(1);
            in_ring <= (32'(in_ring) == RING - 1) ? '0 : in_ring + RGW'(1);
          end
        end else begin
          in_col <= in_col + CW'(1);
        end
      end
      if ((state == ST_MED) && out_free) begin
        if (emit_last) begin
          emit_col  <= '0;
          emit_row  <= '0;
          emit_ring <= '0;
          in_done   <= 1'b0;
        end else if ((CW+1)'(emit_col) + (CW+1)'(1) >= w_eff) begin
          emit_col  <= '0;
          emit_row  <= emit_row + RW'(1);
          emit_ring <= (32'(emit_ring) == RING - 1) ? '0 : emit_ring + RGW'(1);
        end else begin
          emit_col <= emit_col + CW'(1);
        end
      end
    end
  end

  // Walk the window row by row, one cell a cycle.
  always_ff @(posedge clk) begin
    if (state == ST_CHECK) begin
      r_cur   <= $signed({2'b00, emit_row}) - $signed((RW+2)'(k_eff));
      c_cur   <= $signed({2'b00, emit_col}) - $signed((CW+2)'(k_eff));
      c_base  <= $signed({2'b00, emit_col}) - $signed((CW+2)'(k_eff));
      g_ring  <= RGW'(ring_start);
      gx      <= '0;
      gy      <= '0;
      med_idx <= IW'((sq - (SW+SW)'(1)) >> 1);
    end else if (state == ST_GATHER) begin
      if (gy == s_eff - SW'(1)) begin
        gy     <= '0;
        gx     <= gx + SW'(1);
        c_cur  <= c_base;
        r_cur  <= r_cur + (RW+2)'(1);
        g_ring <= (32'(g_ring) == RING - 1) ? '0 : g_ring + RGW'(1);
      end else begin
        gy    <= gy + SW'(1);
        c_cur <= c_cur + (CW+2)'(1);
      end
    end
  end

  // Read data is registered and lands in the cycle after its address; cells off the frame are zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      ins_en_d <= 1'b0;
    end else begin
      ins_en_d <= (state == ST_GATHER);
    end
    ins_zero_d <= !in_frame;
  end

  assign ins_val = ins_zero_d ? '0 : rd_data;

  // Sort chain: cells stay in ascending order, empty cells at the top.
  wmf_link_t        chain [NCELL+1];
  logic [PIX_W-1:0] cell_val [NCELL];

  assign chain[0] = '{keep: 1'b1, valid: 1'b1, value: '0};

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    wmf_sort_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .clear   (sort_clear),
      .ins_en  (ins_en_d),
      .ins_val (ins_val),
      .prev    (chain[i]),
      .link    (chain[i+1])
    );
    assign cell_val[i] = chain[i+1].value;
  end

  assign median = cell_val[med_idx];

  // Output register: hold a result until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if ((state == ST_MED) && out_free) begin
      out_full <= 1'b1;
    end else if (m_tready) begin
      out_full <= 1'b0;
    end
    if ((state == ST_MED) && out_free) begin
      out_pix  <= median;
      out_col  <= OUT_POS_W'(emit_col);
      out_row  <= OUT_POS_W'(emit_row);
      out_last <= emit_last;
    end
  end

  assign m_tvalid = out_full;
  assign m_tdata  = {2'b00, out_row, out_col, out_pix};
  assign m_tlast  = out_last;

endmodule
`default_nettype wire

// File: design/wmf_checker.sv
// ----------------------------------------------------------------------------
// Window median filter port checker
// Port-level checks on the stream handshakes and the sequencing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "window_median_filter_unit_macros.svh"
module wmf_checker
  import wmf_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_tvalid,
  input wire logic                 s_tready,
  input wire logic [PIX_W-1:0]     s_tdata,
  input wire logic                 s_tuser,
  input wire logic                 m_tvalid,
  input wire logic                 m_tready,
  input wire logic [31:0]          m_tdata,
  input wire logic                 m_tlast,
  input wire logic                 cfg_we,
  input wire logic [CFG_IDX_W-1:0] cfg_index,
  input wire logic [DIM_W-1:0]     cfg_data
);

  logic unused;
  assign unused = ^{s_tdata, s_tuser, cfg_we, cfg_index, cfg_data};

  `WMF_ASSERT(a_out_hold, clk, rst, (m_tvalid && !m_tready) |=> m_tvalid)
  `WMF_ASSERT(a_out_stable, clk, rst, (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tlast)))
  // Each transfer in is checked before the next one is taken.
  `WMF_ASSERT(a_one_at_a_time, clk, rst, (s_tvalid && s_tready) |=> !s_tready)
  // Reset empties the output register and leaves the input open.
  `WMF_ASSERT_ALWAYS(a_reset_clean, clk, rst |=> (!m_tvalid && s_tready))

endmodule

bind window_median_filter_unit wmf_checker u_wmf_checker (.*);
`default_nettype wire
